// ===== sv/aifc_pkg.sv =====
package aifc_pkg;

  localparam int SECTOR_BYTES = 2048;
  localparam int IDX_W        = $clog2(SECTOR_BYTES + 1);
  localparam int POS_W        = 34;
  localparam int START_W      = 12;
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] TAG_FORM = 32'h464F524D;
  localparam logic [WORD_W-1:0] TAG_AIFC = 32'h41494643;
  localparam logic [WORD_W-1:0] TAG_SSND = 32'h53534E44;

  localparam logic [POS_W-1:0] HDR_FIRST      = 34'd12;
  localparam logic [POS_W-1:0] SSND_DATA_OFFS = 34'd16;
  localparam logic [POS_W-1:0] HDR_LEN        = 34'd8;

  localparam logic [IDX_W-1:0] IDX_FORM_TAG  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_FORM_SIZE = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_AIFC_TAG  = IDX_W'(11);
  localparam logic [IDX_W:0]   MIN_BYTES     = (IDX_W + 1)'(12);

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NOT_FORM = 3'd2;
  localparam logic [2:0] ST_NOT_AIFC = 3'd3;
  localparam logic [2:0] ST_NO_SSND  = 3'd4;

  typedef enum logic [2:0] {
    PH_FORM_TAG  = 3'd0,
    PH_FORM_SIZE = 3'd1,
    PH_AIFC_TAG  = 3'd2,
    PH_WALK      = 3'd3,
    PH_BAD_FORM  = 3'd4,
    PH_BAD_AIFC  = 3'd5,
    PH_PAST_END  = 3'd6
  } aifc_phase_t;

  // One byte after assembly: the word ending at this byte and where it sits.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              in_sector;
    logic              last;
  } aifc_entry_t;

endpackage

// ===== sv/aifc_ssnd_chunk_locator.sv =====
// Sound-chunk locator for one sector of an AIFF-C stream, one byte per item.
// Throughput: one byte per cycle while the result side keeps up.
// A result on out_valid is registered: the byte that causes it passes
// first through the byte queue and then the parser's output register.
// Reset (synchronous, rst_n low) empties the queue and restarts at offset zero.
module aifc_ssnd_chunk_locator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_audio_start,
  output logic [31:0] out_audio_size
);
  import aifc_pkg::*;

  logic        push, full, pop, ent_valid;
  aifc_entry_t push_entry, ent;

  assign in_ready = !full;

  aifc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_entry   (push_entry)
  );

  aifc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_valid  (ent_valid),
    .pop_entry  (ent)
  );

  aifc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .ent_valid       (ent_valid),
    .ent             (ent),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_audio_start (out_audio_start),
    .out_audio_size  (out_audio_size)
  );

endmodule

// ===== sv/aifc_front.sv =====
module aifc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 push,
  output aifc_pkg::aifc_entry_t push_entry
);
  import aifc_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              in_sector;

  assign push      = in_valid && in_ready;
  assign in_sector = idx_r < IDX_W'(SECTOR_BYTES);

  always_comb begin
    word_nxt = in_sector ? {word_r[WORD_W-9:0], in_data_byte} : word_r;
    idx_nxt  = in_sector ? idx_r + IDX_W'(1) : idx_r;
    push_entry.word      = word_nxt;
    push_entry.idx       = idx_r;
    push_entry.in_sector = in_sector;
    push_entry.last      = in_last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      word_r <= '0;
    end else if (push) begin
      if (in_last_byte) begin
        idx_r  <= '0;
        word_r <= '0;
      end else begin
        idx_r  <= idx_nxt;
        word_r <= word_nxt;
      end
    end
  end

endmodule

// ===== sv/aifc_fifo.sv =====
module aifc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  aifc_pkg::aifc_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output aifc_pkg::aifc_entry_t pop_entry
);
  import aifc_pkg::*;

  aifc_entry_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_pop;

  assign full      = count_r == 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");
`endif

endmodule

// ===== sv/aifc_back.sv =====
module aifc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ent_valid,
  input  aifc_pkg::aifc_entry_t ent,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [11:0]           out_audio_start,
  output logic [31:0]           out_audio_size
);
  import aifc_pkg::*;

  aifc_phase_t        phase_r, phase_nxt;
  logic [WORD_W-1:0]  form_size_r, form_size_nxt;
  logic [WORD_W-1:0]  chunk_tag_r, chunk_tag_nxt;
  logic [POS_W-1:0]   hdr_pos_r, hdr_pos_nxt;
  logic               reported_r, reported_nxt;

  logic               out_valid_r;
  logic [2:0]         status_r, status_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [WORD_W-1:0]  size_r, size_nxt;
  logic               emit;

  logic [POS_W-1:0]   idx_w;
  logic [POS_W-1:0]   body_len;
  logic [IDX_W:0]     taken;
  logic               tag_hit, size_hit, past_end;

  assign pop             = ent_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_audio_start = start_r;
  assign out_audio_size  = size_r;

  assign idx_w    = POS_W'(ent.idx);
  assign tag_hit  = idx_w == hdr_pos_r + POS_W'(3);
  assign size_hit = idx_w == hdr_pos_r + POS_W'(7);
  assign past_end = hdr_pos_r >= (POS_W'(form_size_r) + HDR_LEN);
  // Chunk bodies are padded to an even length.
  assign body_len = (POS_W'(ent.word) + POS_W'(1)) & ~POS_W'(1);
  assign taken    = ent.in_sector ? {1'b0, ent.idx} + (IDX_W + 1)'(1) : {1'b0, ent.idx};

  always_comb begin
    phase_nxt     = phase_r;
    form_size_nxt = form_size_r;
    chunk_tag_nxt = chunk_tag_r;
    hdr_pos_nxt   = hdr_pos_r;
    reported_nxt  = reported_r;
    emit          = 1'b0;
    status_nxt    = status_r;
    start_nxt     = start_r;
    size_nxt      = size_r;

    if (pop) begin
      if (!reported_r && ent.in_sector) begin
        unique case (phase_r)
          PH_FORM_TAG: begin
            if (ent.idx == IDX_FORM_TAG) begin
              phase_nxt = (ent.word == TAG_FORM) ? PH_FORM_SIZE : PH_BAD_FORM;
            end
          end
          PH_FORM_SIZE: begin
            if (ent.idx == IDX_FORM_SIZE) begin
              form_size_nxt = ent.word;
              phase_nxt     = PH_AIFC_TAG;
            end
          end
          PH_AIFC_TAG: begin
            if (ent.idx == IDX_AIFC_TAG) begin
              phase_nxt = (ent.word == TAG_AIFC) ? PH_WALK : PH_BAD_AIFC;
            end
          end
          PH_WALK: begin
            if (tag_hit) begin
              chunk_tag_nxt = ent.word;
            end else if (size_hit) begin
              if (past_end) begin
                phase_nxt = PH_PAST_END;
              end else if (chunk_tag_r == TAG_SSND) begin
                emit         = 1'b1;
                reported_nxt = 1'b1;
                status_nxt   = ST_FOUND;
                start_nxt    = START_W'(hdr_pos_r + SSND_DATA_OFFS);
                size_nxt     = ent.word - WORD_W'(8);
              end else begin
                hdr_pos_nxt = hdr_pos_r + HDR_LEN + body_len;
              end
            end
          end
          default: ;
        endcase
      end

      if (ent.last) begin
        if (!reported_nxt) begin
          emit      = 1'b1;
          start_nxt = '0;
          size_nxt  = '0;
          if (taken < MIN_BYTES) begin
            status_nxt = ST_SHORT;
          end else if (phase_nxt == PH_BAD_FORM) begin
            status_nxt = ST_NOT_FORM;
          end else if (phase_nxt == PH_BAD_AIFC) begin
            status_nxt = ST_NOT_AIFC;
          end else begin
            status_nxt = ST_NO_SSND;
          end
        end
        phase_nxt     = PH_FORM_TAG;
        form_size_nxt = '0;
        chunk_tag_nxt = '0;
        hdr_pos_nxt   = HDR_FIRST;
        reported_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FORM_TAG;
      form_size_r <= '0;
      chunk_tag_r <= '0;
      hdr_pos_r   <= HDR_FIRST;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      form_size_r <= form_size_nxt;
      chunk_tag_r <= chunk_tag_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      reported_r  <= reported_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
      size_r   <= size_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_report_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> phase_r == PH_WALK)
    else $error("report flag set outside the chunk walk");
  a_hdr_even: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r[0] == 1'b0)
    else $error("chunk header position is odd");
  a_sector_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ent.last) |=> (!reported_r && phase_r == PH_FORM_TAG && hdr_pos_r == HDR_FIRST))
    else $error("state not restarted after the final byte");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result overwritten before it was taken");
`endif

endmodule
